// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the parser's RTL files.
// No dependencies; each macro takes its clock and reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cihp_pkg.sv -----
// Package for the CBOR item head parser: result codes, parser phases and
// the step record that travels from the front end to the result stage.
// No dependencies.
package cihp_pkg;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_HEAD    = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   // Error codes
   typedef enum logic [1:0] {
      ERR_BAD_INFO   = 2'd0,
      ERR_HEAD_TRUNC = 2'd1,
      ERR_PAY_TRUNC  = 2'd2
   } err_type;

   // Parser phases
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_EXT     = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_DROP    = 2'd3
   } phase_type;

   localparam int VALUE_W = 64;
   localparam int BYTE_W  = 8;
   localparam int MAJOR_W = 3;
   localparam int INFO_W  = 5;
   localparam int EXT_W   = 4;

   localparam logic [INFO_W-1:0] INFO_MASK  = 5'h1F;
   localparam logic [INFO_W-1:0] INFO_EXT_1 = 5'd24;
   localparam logic [INFO_W-1:0] INFO_EXT_2 = 5'd25;
   localparam logic [INFO_W-1:0] INFO_EXT_4 = 5'd26;
   localparam logic [INFO_W-1:0] INFO_EXT_8 = 5'd27;

   localparam logic [MAJOR_W-1:0] MAJ_BYTES = 3'd2;
   localparam logic [MAJOR_W-1:0] MAJ_TEXT  = 3'd3;

   // Queue between front end and result stage
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   // Results of one input byte: a first result and, optionally, a trailing
   // payload-truncated error with the same major type.
   typedef struct packed {
      kind_type                 kind;
      logic [MAJOR_W-1:0]       major;
      logic [VALUE_W-1:0]       value;
      logic [BYTE_W-1:0]        pbyte;
      err_type                  ecode;
      logic                     done;
      logic                     two;
   } rec_type;

endpackage

// ----- hdl/cbor_item_head_parser_top.sv -----
// Top level of the CBOR item head parser: front end, record queue and
// result stage. Depends on cihp_pkg, cihp_front, cihp_queue, cihp_back.
//
//   Channel   Ports           Handshake                 Moves
//   request   req_*           push / full               one encoded byte + end flag
//   response  rsp_*           empty / pop               one decoded result
//
// One byte is accepted per cycle while the queue is not full; each byte is decoded
// in the cycle it is taken. A byte gives zero, one or two results; the result stage
// sends one per cycle while the receiver pops, so two results of a byte leave in turn.
// A result passes through a queue entry and then the output register before it shows.
// Reset clears the parser phase, the queue and the output register.
// A stalled result side fills the four-record queue, then raises full.
module cbor_item_head_parser_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [cihp_pkg::BYTE_W-1:0]    req_byte_in,
   input  logic                           req_final_byte,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [1:0]                     rsp_kind,
   output logic [cihp_pkg::MAJOR_W-1:0]   rsp_major_type,
   output logic [cihp_pkg::VALUE_W-1:0]   rsp_head_value,
   output logic [cihp_pkg::BYTE_W-1:0]    rsp_payload_byte,
   output logic [1:0]                     rsp_error_code,
   output logic                           rsp_item_done,
   output logic                           rsp_run_end
);
   import cihp_pkg::*;

   logic      accept;
   logic      rec_push;
   rec_type   wr_rec;
   rec_type   rd_rec;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;

   // Take a byte whenever the queue has room
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   cihp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_in    (req_byte_in),
      .final_byte (req_final_byte),
      .rec_push   (rec_push),
      .rec        (wr_rec)
   );

   cihp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (rec_push),
      .wr_rec (wr_rec),
      .full   (q_full),
      .pop    (q_pop),
      .rd_rec (rd_rec),
      .empty  (q_empty)
   );

   cihp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_rec            (rd_rec),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_major_type   (rsp_major_type),
      .rsp_head_value   (rsp_head_value),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_error_code   (rsp_error_code),
      .rsp_item_done    (rsp_item_done),
      .rsp_run_end      (rsp_run_end)
   );

endmodule

// ----- hdl/cihp_front.sv -----
// Front end of the CBOR item head parser: decodes each accepted byte and
// produces the step record for it. Depends on cihp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cihp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [cihp_pkg::BYTE_W-1:0]  byte_in,
   input  logic                         final_byte,
   output logic                         rec_push,
   output cihp_pkg::rec_type            rec
);
   import cihp_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [MAJOR_W-1:0]   major_ff, major_in;
   logic [EXT_W-1:0]     ext_left_ff, ext_left_in;
   logic [VALUE_W-1:0]   accum_ff, accum_in;
   logic [VALUE_W-1:0]   pay_left_ff, pay_left_in;

   logic [INFO_W-1:0]    info;
   logic [MAJOR_W-1:0]   fin_major;
   logic [VALUE_W-1:0]   fin_value;
   logic                 need_pay;
   logic                 ext_last;
   logic                 pay_last;

   // Decode fields shared by both blocks
   always_comb begin
      info      = byte_in[INFO_W-1:0] & INFO_MASK;
      fin_major = (phase_ff == PH_IDLE) ? byte_in[BYTE_W-1:INFO_W] : major_ff;
      fin_value = (phase_ff == PH_IDLE) ? {{(VALUE_W-INFO_W){1'b0}}, info}
                                        : {accum_ff[VALUE_W-BYTE_W-1:0], byte_in};
      need_pay  = ((fin_major == MAJ_BYTES) || (fin_major == MAJ_TEXT))
                  && (fin_value != '0);
      ext_last  = (ext_left_ff == EXT_W'(1));
      pay_last  = (pay_left_ff == VALUE_W'(1));
   end

   // Next state
   always_comb begin
      phase_in    = phase_ff;
      major_in    = major_ff;
      ext_left_in = ext_left_ff;
      accum_in    = accum_ff;
      pay_left_in = pay_left_ff;
      case (phase_ff)
         PH_IDLE: begin
            major_in = fin_major;
            if (info < INFO_EXT_1) begin
               pay_left_in = fin_value;
               phase_in    = (need_pay && !final_byte) ? PH_PAYLOAD : PH_IDLE;
            end else if (info inside {[INFO_EXT_1:INFO_EXT_8]}) begin
               ext_left_in = EXT_W'(1) << info[1:0];
               accum_in    = '0;
               phase_in    = final_byte ? PH_IDLE : PH_EXT;
            end else begin
               phase_in = final_byte ? PH_IDLE : PH_DROP;
            end
         end
         PH_EXT: begin
            accum_in    = fin_value;
            ext_left_in = ext_left_ff - EXT_W'(1);
            if (ext_last) begin
               pay_left_in = fin_value;
               phase_in    = (need_pay && !final_byte) ? PH_PAYLOAD : PH_IDLE;
            end else if (final_byte) begin
               phase_in = PH_IDLE;
            end
         end
         PH_PAYLOAD: begin
            pay_left_in = pay_left_ff - VALUE_W'(1);
            if (pay_last || final_byte) begin
               phase_in = PH_IDLE;
            end
         end
         PH_DROP: begin
            if (final_byte) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Step record
   always_comb begin
      rec_push  = 1'b0;
      rec.kind  = KIND_HEAD;
      rec.major = fin_major;
      rec.value = '0;
      rec.pbyte = '0;
      rec.ecode = ERR_BAD_INFO;
      rec.done  = 1'b0;
      rec.two   = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (info < INFO_EXT_1) begin
               rec_push  = accept;
               rec.value = fin_value;
               rec.done  = !need_pay;
               rec.two   = need_pay && final_byte;
            end else if (info inside {[INFO_EXT_1:INFO_EXT_8]}) begin
               rec_push  = accept && final_byte;
               rec.kind  = KIND_ERROR;
               rec.ecode = ERR_HEAD_TRUNC;
            end else begin
               rec_push  = accept;
               rec.kind  = KIND_ERROR;
               rec.ecode = ERR_BAD_INFO;
            end
         end
         PH_EXT: begin
            if (ext_last) begin
               rec_push  = accept;
               rec.value = fin_value;
               rec.done  = !need_pay;
               rec.two   = need_pay && final_byte;
            end else begin
               rec_push  = accept && final_byte;
               rec.kind  = KIND_ERROR;
               rec.ecode = ERR_HEAD_TRUNC;
            end
         end
         PH_PAYLOAD: begin
            rec_push  = accept;
            rec.kind  = KIND_PAYLOAD;
            rec.pbyte = byte_in;
            rec.done  = pay_last;
            rec.two   = !pay_last && final_byte;
         end
         default: begin
            rec_push = 1'b0;
         end
      endcase
   end

   // Advance state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         major_ff    <= '0;
         ext_left_ff <= '0;
         accum_ff    <= '0;
         pay_left_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         major_ff    <= major_in;
         ext_left_ff <= ext_left_in;
         accum_ff    <= accum_in;
         pay_left_ff <= pay_left_in;
      end
   end

   `ASSERT_ALWAYS(a_ext_count, clock, reset, (phase_ff != PH_EXT) || (ext_left_ff != '0), "argument phase with no bytes left")
   `ASSERT_ALWAYS(a_pay_count, clock, reset, (phase_ff != PH_PAYLOAD) || (pay_left_ff != '0), "payload phase with no bytes left")
   `ASSERT_ALWAYS(a_two_kind, clock, reset, !(rec_push && rec.two) || (rec.kind != KIND_ERROR), "trailing error after an error result")

endmodule

// ----- hdl/cihp_queue.sv -----
// Short record queue between the parser front end and the result stage.
// Depends on cihp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cihp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cihp_pkg::rec_type  wr_rec,
   output logic               full,
   input  logic               pop,
   output cihp_pkg::rec_type  rd_rec,
   output logic               empty
);
   import cihp_pkg::*;

   rec_type              entry_ff [Q_DEPTH];
   logic [Q_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0]      count_ff, count_in;

   // Pointer and fill count update
   always_comb begin
      full      = (count_ff == Q_CW'(Q_DEPTH));
      empty     = (count_ff == '0);
      wr_ptr_in = wr_ptr_ff + Q_AW'(push);
      rd_ptr_in = rd_ptr_ff + Q_AW'(pop);
      count_in  = count_ff + Q_CW'(push) - Q_CW'(pop);
      rd_rec    = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_rec;
      end
   end

   `ASSERT_ALWAYS(a_no_overflow, clock, reset, !(push && full && !pop), "push into a full queue")
   `ASSERT_ALWAYS(a_no_underflow, clock, reset, !(pop && empty), "pop from an empty queue")
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= Q_CW'(Q_DEPTH), "fill count out of range")

endmodule

// ----- hdl/cihp_back.sv -----
// Result stage of the CBOR item head parser: splits each step record into
// one or two results and holds the oldest one on the result ports.
// Depends on cihp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cihp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  cihp_pkg::rec_type              q_rec,
   input  logic                           q_empty,
   output logic                           q_pop,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [1:0]                     rsp_kind,
   output logic [cihp_pkg::MAJOR_W-1:0]   rsp_major_type,
   output logic [cihp_pkg::VALUE_W-1:0]   rsp_head_value,
   output logic [cihp_pkg::BYTE_W-1:0]    rsp_payload_byte,
   output logic [1:0]                     rsp_error_code,
   output logic                           rsp_item_done,
   output logic                           rsp_run_end
);
   import cihp_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 pend_ff, pend_in;
   kind_type             kind_ff, kind_in;
   logic [MAJOR_W-1:0]   major_ff, major_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [BYTE_W-1:0]    pbyte_ff, pbyte_in;
   err_type              ecode_ff, ecode_in;
   logic                 done_ff, done_in;
   logic                 run_end_ff, run_end_in;
   logic                 load;

   // Refill the output register when it is empty or being taken
   always_comb begin
      load       = !valid_ff || rsp_pop;
      q_pop      = load && !pend_ff && !q_empty;
      valid_in   = valid_ff;
      pend_in    = pend_ff;
      kind_in    = kind_ff;
      major_in   = major_ff;
      value_in   = value_ff;
      pbyte_in   = pbyte_ff;
      ecode_in   = ecode_ff;
      done_in    = done_ff;
      run_end_in = run_end_ff;
      if (load) begin
         if (pend_ff) begin
            // Emit the trailing payload-truncated error
            valid_in   = 1'b1;
            pend_in    = 1'b0;
            kind_in    = KIND_ERROR;
            value_in   = '0;
            pbyte_in   = '0;
            ecode_in   = ERR_PAY_TRUNC;
            done_in    = 1'b0;
            run_end_in = 1'b1;
         end else if (!q_empty) begin
            valid_in   = 1'b1;
            pend_in    = q_rec.two;
            kind_in    = q_rec.kind;
            major_in   = q_rec.major;
            value_in   = q_rec.value;
            pbyte_in   = q_rec.pbyte;
            ecode_in   = q_rec.ecode;
            done_in    = q_rec.done;
            run_end_in = !q_rec.two;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      major_ff   <= major_in;
      value_ff   <= value_in;
      pbyte_ff   <= pbyte_in;
      ecode_ff   <= ecode_in;
      done_ff    <= done_in;
      run_end_ff <= run_end_in;
   end

   // Drive result ports
   assign rsp_empty        = !valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_major_type   = major_ff;
   assign rsp_head_value   = value_ff;
   assign rsp_payload_byte = pbyte_ff;
   assign rsp_error_code   = ecode_ff;
   assign rsp_item_done    = done_ff;
   assign rsp_run_end      = run_end_ff;

   `ASSERT_ALWAYS(a_pend_valid, clock, reset, !pend_ff || (valid_ff && !run_end_ff), "pending error without a held first result")
   `ASSERT_NEXT(a_pend_follow, clock, reset, pend_ff && rsp_pop, valid_ff && run_end_ff && (kind_ff == KIND_ERROR), "trailing error did not follow")

endmodule

// ----- bench/cbor_item_head_parser_top_tb.sv -----
// Self-checking bench for the CBOR item head parser: directed heads, strings
// and error cases, then random buffers under several flow-control mixes.
// Depends on cihp_pkg and cbor_item_head_parser_top.
`timescale 1ns / 100ps

module cbor_item_head_parser_top_tb;
   import cihp_pkg::*;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 12;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int BYTES_PER_MIX  = 488;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 16;
   localparam int MAX_PRINTED    = 100;

   // Major types without a package name
   localparam logic [MAJOR_W-1:0] MAJ_UINT   = 3'd0;
   localparam logic [MAJOR_W-1:0] MAJ_NINT   = 3'd1;
   localparam logic [MAJOR_W-1:0] MAJ_ARRAY  = 3'd4;
   localparam logic [MAJOR_W-1:0] MAJ_MAP    = 3'd5;
   localparam logic [MAJOR_W-1:0] MAJ_TAG    = 3'd6;
   localparam logic [MAJOR_W-1:0] MAJ_SIMPLE = 3'd7;

   localparam logic [INFO_W-1:0] INFO_DIRECT_MAX = INFO_EXT_1 - 5'd1;
   localparam logic [INFO_W-1:0] INFO_BAD_FIRST  = INFO_EXT_8 + 5'd1;

   // The error field reads as the first code whenever no error is reported
   localparam err_type ERR_NONE = ERR_BAD_INFO;

   typedef struct {
      kind_type            kind;
      logic [MAJOR_W-1:0]  major;
      logic [VALUE_W-1:0]  value;
      logic [BYTE_W-1:0]   pbyte;
      err_type             ecode;
      logic                done;
      logic                last;
   } head_result_type;

   // Parser shadow plus the queue of results it still owes
   class head_scoreboard_type;
      phase_type           phase;
      logic [MAJOR_W-1:0]  item_major;
      logic [EXT_W-1:0]    ext_left;
      logic [VALUE_W-1:0]  value_acc;
      logic [VALUE_W-1:0]  payload_left;
      head_result_type     owed[$];
      int                  mismatches;
      int                  bytes_in;
      int                  live_bytes;
      int                  checked;
      int                  heads;
      int                  payloads;
      int                  errors;

      function new();
         phase        = PH_IDLE;
         item_major   = '0;
         ext_left     = '0;
         value_acc    = '0;
         payload_left = '0;
         mismatches   = 0;
         bytes_in     = 0;
         live_bytes   = 0;
         checked      = 0;
         heads        = 0;
         payloads     = 0;
         errors       = 0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function void owe(kind_type kind, logic [VALUE_W-1:0] value, logic [BYTE_W-1:0] pbyte,
                        err_type ecode, logic done);
         head_result_type r;
         r.kind  = kind;
         r.major = item_major;
         r.value = value;
         r.pbyte = pbyte;
         r.ecode = ecode;
         r.done  = done;
         r.last  = 1'b0;
         owed.push_back(r);
      endfunction

      // Report a finished head; open the payload of a non-empty string, or owe its error on the final byte
      function void close_head(logic [VALUE_W-1:0] value, logic fin);
         logic need_payload;
         need_payload = (item_major == MAJ_BYTES || item_major == MAJ_TEXT) && value != '0;
         owe(KIND_HEAD, value, '0, ERR_NONE, !need_payload);
         phase = PH_IDLE;
         if (need_payload) begin
            if (fin) begin
               owe(KIND_ERROR, '0, '0, ERR_PAY_TRUNC, 1'b0);
            end else begin
               payload_left = value;
               phase        = PH_PAYLOAD;
            end
         end
      endfunction

      // Note one accepted byte and queue the results it causes
      function void note_byte(logic [BYTE_W-1:0] b, logic fin);
         logic [INFO_W-1:0] info;
         head_result_type   r;
         int                first;
         first = owed.size();
         bytes_in++;
         if (phase != PH_DROP)
            live_bytes++;
         case (phase)
            PH_IDLE: begin
               info       = b[INFO_W-1:0];
               item_major = b[BYTE_W-1 -: MAJOR_W];
               if (info < INFO_EXT_1) begin
                  close_head(VALUE_W'(info), fin);
               end else if (info <= INFO_EXT_8) begin
                  ext_left  = EXT_W'(1 << (info - INFO_EXT_1));
                  value_acc = '0;
                  if (fin)
                     owe(KIND_ERROR, '0, '0, ERR_HEAD_TRUNC, 1'b0);
                  else
                     phase = PH_EXT;
               end else begin
                  owe(KIND_ERROR, '0, '0, ERR_BAD_INFO, 1'b0);
                  phase = fin ? PH_IDLE : PH_DROP;
               end
            end
            PH_EXT: begin
               value_acc = {value_acc[VALUE_W-BYTE_W-1:0], b};
               ext_left  = ext_left - 1'b1;
               if (ext_left == '0) begin
                  close_head(value_acc, fin);
               end else if (fin) begin
                  owe(KIND_ERROR, '0, '0, ERR_HEAD_TRUNC, 1'b0);
                  phase = PH_IDLE;
               end
            end
            PH_PAYLOAD: begin
               payload_left = payload_left - 1'b1;
               owe(KIND_PAYLOAD, '0, b, ERR_NONE, payload_left == '0);
               if (payload_left == '0) begin
                  phase = PH_IDLE;
               end else if (fin) begin
                  owe(KIND_ERROR, '0, '0, ERR_PAY_TRUNC, 1'b0);
                  phase = PH_IDLE;
               end
            end
            default: begin
               if (fin)
                  phase = PH_IDLE;
            end
         endcase
         // Mark the last result of this byte
         if (owed.size() > first) begin
            r      = owed.pop_back();
            r.last = 1'b1;
            owed.push_back(r);
         end
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch on result %0d: %s", $realtime, checked, msg);
      endtask

      task compare_field(string name, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      endtask

      // Compare one transferred result with the oldest owed one
      task check_result(logic [1:0] kind, logic [MAJOR_W-1:0] major,
                        logic [VALUE_W-1:0] value, logic [BYTE_W-1:0] pbyte,
                        logic [1:0] ecode, logic done, logic last);
         head_result_type e;
         checked++;
         if (owed.size() == 0) begin
            report_mismatch($sformatf("kind %0d arrived with nothing owed", kind));
            return;
         end
         e = owed.pop_front();
         case (e.kind)
            KIND_HEAD:    heads++;
            KIND_PAYLOAD: payloads++;
            default:      errors++;
         endcase
         compare_field("kind", VALUE_W'(kind), VALUE_W'(e.kind));
         compare_field("major_type", VALUE_W'(major), VALUE_W'(e.major));
         compare_field("head_value", value, e.value);
         compare_field("payload_byte", VALUE_W'(pbyte), VALUE_W'(e.pbyte));
         compare_field("error_code", VALUE_W'(ecode), VALUE_W'(e.ecode));
         compare_field("item_done", VALUE_W'(done), VALUE_W'(e.done));
         compare_field("run_end", VALUE_W'(last), VALUE_W'(e.last));
      endtask

      task check_drained();
         if (owed.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed.size()));
      endtask
   endclass

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_push       = 1'b0;
   logic                 req_full;
   logic [BYTE_W-1:0]    req_byte_in    = '0;
   logic                 req_final_byte = 1'b0;
   logic                 rsp_empty;
   logic                 rsp_pop        = 1'b0;
   logic [1:0]           rsp_kind;
   logic [MAJOR_W-1:0]   rsp_major_type;
   logic [VALUE_W-1:0]   rsp_head_value;
   logic [BYTE_W-1:0]    rsp_payload_byte;
   logic [1:0]           rsp_error_code;
   logic                 rsp_item_done;
   logic                 rsp_run_end;

   head_scoreboard_type  sb;
   int                   idle_pct    = 0;
   int                   stall_pct   = 0;
   int                   hold_left   = 0;
   int                   cycle_count = 0;
   logic [BYTE_W-1:0]    buf_data[$];
   logic                 buf_last[$];

   cbor_item_head_parser_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_byte_in      (req_byte_in),
      .req_final_byte   (req_final_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_major_type   (rsp_major_type),
      .rsp_head_value   (rsp_head_value),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_error_code   (rsp_error_code),
      .rsp_item_done    (rsp_item_done),
      .rsp_run_end      (rsp_run_end)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                  sb.pending());
         $display("cbor_item_head_parser_top_tb failed");
         $finish;
      end
   end

   // Check each transferred result, then pick pop for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_result(rsp_kind, rsp_major_type, rsp_head_value, rsp_payload_byte,
                         rsp_error_code, rsp_item_done, rsp_run_end);
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   function automatic logic [BYTE_W-1:0] head_byte(logic [MAJOR_W-1:0] major,
                                                   logic [INFO_W-1:0] info);
      return {major, info};
   endfunction

   // Offer one byte, idling first at the current rate; return on its transfer
   task automatic send_byte(logic [BYTE_W-1:0] b, logic fin);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_byte_in    <= b;
      req_final_byte <= fin;
      do
         @(posedge clock);
      while (req_full);
      sb.note_byte(b, fin);
   endtask

   // Hold the input until every owed result has been transferred
   task automatic wait_drained();
      req_push <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   function automatic void add_byte(logic [BYTE_W-1:0] b);
      buf_data.push_back(b);
      buf_last.push_back(1'b0);
   endfunction

   // Append one well-formed data item with random content
   function automatic void add_item();
      logic [MAJOR_W-1:0] major;
      logic [INFO_W-1:0]  info;
      logic [VALUE_W-1:0] value;
      logic               is_str;
      int                 form;
      int                 nbytes;
      major  = MAJOR_W'($urandom_range(0, 7));
      is_str = (major == MAJ_BYTES || major == MAJ_TEXT);
      form   = $urandom_range(0, 4);
      if (is_str) begin
         value = ($urandom_range(0, 9) == 0) ? VALUE_W'($urandom_range(24, 40))
                                             : VALUE_W'($urandom_range(0, 5));
         if (value > VALUE_W'(INFO_DIRECT_MAX) && form == 0)
            form = 1;
      end else if (form == 0) begin
         value = VALUE_W'($urandom_range(0, INFO_DIRECT_MAX));
      end else begin
         value = {$urandom, $urandom};
         if ($urandom_range(0, 7) == 0)
            value = '1;
      end
      nbytes = (form == 0) ? 0 : (1 << (form - 1));
      if (nbytes > 0 && nbytes < 8)
         value = value & ((VALUE_W'(1) << (8 * nbytes)) - 1'b1);
      info = (form == 0) ? value[INFO_W-1:0] : INFO_EXT_1 + INFO_W'(form - 1);
      add_byte(head_byte(major, info));
      for (int i = nbytes - 1; i >= 0; i--)
         add_byte(value[8*i +: 8]);
      if (is_str)
         for (int i = 0; i < int'(value); i++)
            add_byte(BYTE_W'($urandom));
   endfunction

   // Build one buffer: mostly well-formed, some cut short, bad or pure noise
   function automatic void build_buffer();
      int pick;
      int cut;
      pick = $urandom_range(0, 99);
      buf_data.delete();
      buf_last.delete();
      repeat ($urandom_range(1, 3))
         add_item();
      if (pick < 70) begin
         // keep the well-formed items as they are
      end else if (pick < 80) begin
         if ($urandom_range(0, 1) == 0) begin
            cut = $urandom_range(1, buf_data.size());
            while (buf_data.size() > cut) begin
               void'(buf_data.pop_back());
               void'(buf_last.pop_back());
            end
         end else begin
            // string with a random eight-byte length, cut short after at most three payload bytes
            add_byte(head_byte($urandom_range(0, 1) ? MAJ_BYTES : MAJ_TEXT, INFO_EXT_8));
            repeat (8)
               add_byte(BYTE_W'($urandom));
            repeat ($urandom_range(0, 3))
               add_byte(BYTE_W'($urandom));
         end
      end else if (pick < 90) begin
         add_byte(head_byte(MAJOR_W'($urandom_range(0, 7)),
                            INFO_W'($urandom_range(INFO_BAD_FIRST, INFO_MASK))));
         repeat ($urandom_range(0, 3))
            add_byte(BYTE_W'($urandom));
      end else begin
         buf_data.delete();
         buf_last.delete();
         repeat ($urandom_range(1, 6)) begin
            buf_data.push_back(BYTE_W'($urandom));
            buf_last.push_back($urandom_range(0, 3) == 0);
         end
      end
      buf_last[buf_last.size() - 1] = 1'b1;
   endfunction

   task automatic send_random(int target);
      while (sb.live_bytes < target) begin
         build_buffer();
         for (int i = 0; i < buf_data.size(); i++)
            send_byte(buf_data[i], buf_last[i]);
      end
   endtask

   task automatic send_directed();
      // smallest and largest direct arguments
      send_byte(head_byte(MAJ_UINT, 5'd0), 1'b1);
      send_byte(head_byte(MAJ_SIMPLE, INFO_DIRECT_MAX), 1'b1);
      // largest eight-byte argument
      send_byte(head_byte(MAJ_NINT, INFO_EXT_8), 1'b0);
      repeat (7)
         send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      // empty byte string completes at once
      send_byte(head_byte(MAJ_BYTES, 5'd0), 1'b1);
      // complete two-byte text string
      send_byte(head_byte(MAJ_TEXT, 5'd2), 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b1);
      // bad additional info, then bytes dropped up to the end flag
      send_byte(head_byte(MAJ_MAP, INFO_BAD_FIRST), 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      // head cut short inside its argument
      send_byte(head_byte(MAJ_TAG, INFO_EXT_2), 1'b0);
      send_byte(8'h12, 1'b1);
      // head cut short on the initial byte
      send_byte(head_byte(MAJ_ARRAY, INFO_EXT_1), 1'b1);
      // payload cut short after one byte
      send_byte(head_byte(MAJ_BYTES, 5'd3), 1'b0);
      send_byte(8'h01, 1'b1);
      // string head on the final byte: head then payload error
      send_byte(head_byte(MAJ_TEXT, 5'd1), 1'b1);
   endtask

   initial begin
      sb = new();
      repeat (RESET_CYCLES)
         @(posedge clock);
      reset <= 1'b0;

      // No idling on either side
      idle_pct  = 0;
      stall_pct = 0;
      send_directed();
      send_random(BYTES_PER_MIX);
      wait_drained();

      // Sparse sender
      idle_pct = 72;
      send_random(2 * BYTES_PER_MIX);
      wait_drained();

      // Slow receiver; open with a long hold so the input backs up
      idle_pct  = 0;
      stall_pct = 72;
      hold_left = LONG_HOLD;
      send_random(3 * BYTES_PER_MIX);
      wait_drained();

      // Both sides idle
      idle_pct  = 29;
      stall_pct = 29;
      send_random(4 * BYTES_PER_MIX);
      wait_drained();

      // Let any stray result show up
      stall_pct = 0;
      repeat (SETTLE_CYCLES)
         @(posedge clock);
      sb.check_drained();

      $display("%0d bytes sent (%0d outside error recovery), %0d results checked",
               sb.bytes_in, sb.live_bytes, sb.checked);
      $display("%0d heads, %0d payload bytes, %0d errors over four flow-control mixes",
               sb.heads, sb.payloads, sb.errors);
      if (sb.mismatches == 0) begin
         $display("cbor_item_head_parser_top_tb passed");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("cbor_item_head_parser_top_tb failed");
      end
      $finish;
   end

endmodule
